// ===== rtl/core/lzw_byte_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// LZW byte encoder assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LZW_BYTE_ENCODER_DEFINES_SVH
`define LZW_BYTE_ENCODER_DEFINES_SVH

// implication checked every clock, off during reset
`define LZW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW encoder package
// Payload types, constants and the slot hash multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
package lzw_pkg;
  localparam int DictEntries = 4096;
  localparam int TableSlots  = 8192;
  localparam int FirstFree   = 1 << 8;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code;
    logic        final_code;
  } out_item_t;

  // multiplier of the slot hash; the product keeps its low 32 bits
  localparam logic [31:0] HashMul = 32'd2654435761;
endpackage
`default_nettype wire

// ===== rtl/core/lzw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(Depth)-1:0] wr_addr,
  input  wire  [Width-1:0]         wr_data,
  input  wire  [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/lzw_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder
// Hashed dictionary with linear probing, fixed 16-bit output codes.
// ----------------------------------------------------------------------------
// channel | direction | payload             | handshake
// in      | input     | symbol, eos         | in_valid / in_ready
// out     | output    | code, final_code    | out_valid / out_ready
//
// Steps: the first byte of a stream is only accepted; any later byte is
// accepted, then goes through the hash multiply, probe read and compare,
// with further probes on the single RAM read port. A miss adds the emit
// and, while the dictionary has free codes, the insert probe read and its
// compare, plus further insert probes. End of stream adds the final code
// and a clearing pass through all TABLE_SLOTS entries of the dictionary
// RAM. After reset such a clearing pass runs before the first byte is
// taken. A waiting output transaction holds the sequencer before each emit.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_byte_encoder #(
  parameter int DICT_ENTRIES = lzw_pkg::DictEntries,
  parameter int TABLE_SLOTS  = lzw_pkg::TableSlots
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire lzw_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output lzw_pkg::out_item_t      out_data
);
  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int EW = 1 + 16 + 8 + 16;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_AREAD = 4'd8;
  localparam logic [3:0] S_ACMP  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] match_r, match_nxt;
  logic        held_r, held_nxt;
  logic [16:0] free_r, free_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [15:0] outc_r, outc_nxt;
  logic        outf_r, outf_nxt;
  logic        outv_r, outv_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  lzw_ram #(.Width(EW), .Depth(TABLE_SLOTS)) u_dict (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  logic        e_valid;
  logic [15:0] e_prefix, e_code;
  logic [7:0]  e_byte;
  logic [31:0] hkey;
  logic [31:0] hsh;
  logic [AW-1:0] pos_inc;

  assign {e_valid, e_prefix, e_byte, e_code} = rd_data;
  assign hkey    = {match_r, 8'd0} ^ {24'd0, byte_r};
  assign hsh     = prod_r >> 7;
  assign pos_inc = pos_r + AW'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = outv_r;
  assign out_data  = '{code: outc_r, final_code: outf_r};

  always_comb begin
    state_nxt = state_r;
    match_nxt = match_r;
    held_nxt  = held_r;
    free_nxt  = free_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    outc_nxt  = outc_r;
    outf_nxt  = outf_r;
    outv_nxt  = outv_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = '0;
    rd_addr   = pos_r;
    if (outv_r && out_ready) begin
      outv_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        pos_nxt = pos_inc;
        if (pos_r == AW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.symbol;
          last_nxt = in_data.end_of_stream;
          if (!held_r) begin
            match_nxt = {8'd0, in_data.symbol};
            held_nxt  = 1'b1;
            state_nxt = in_data.end_of_stream ? S_FIN : S_IDLE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        prod_nxt  = hkey * lzw_pkg::HashMul;
        state_nxt = S_READ;
      end
      S_READ: begin
        rd_addr   = AW'(hsh % TABLE_SLOTS);
        pos_nxt   = AW'(hsh % TABLE_SLOTS);
        cnt_nxt   = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!e_valid || cnt_r == (AW+1)'(TABLE_SLOTS)) begin
          state_nxt = S_EMIT;
        end else if (e_prefix == match_r && e_byte == byte_r) begin
          match_nxt = e_code;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else begin
          pos_nxt   = pos_inc;
          rd_addr   = pos_inc;
          cnt_nxt   = cnt_r + (AW+1)'(1);
        end
      end
      S_EMIT: begin
        if (!outv_r) begin
          outv_nxt = 1'b1;
          outc_nxt = match_r;
          outf_nxt = 1'b0;
          state_nxt = (free_r >= 17'(DICT_ENTRIES)) ? S_ADD : S_AREAD;
          if (free_r >= 17'(DICT_ENTRIES)) begin
            match_nxt = {8'd0, byte_r};
            state_nxt = last_r ? S_FIN : S_IDLE;
          end else begin
            pos_nxt   = AW'(hsh % TABLE_SLOTS);
            cnt_nxt   = '0;
          end
        end
      end
      S_AREAD: begin
        state_nxt = S_ACMP;
      end
      S_ACMP: begin
        if (!e_valid) begin
          wr_en     = 1'b1;
          wr_data   = {1'b1, match_r, byte_r, free_r[15:0]};
          free_nxt  = free_r + 17'd1;
          match_nxt = {8'd0, byte_r};
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (cnt_r == (AW+1)'(TABLE_SLOTS - 1)) begin
          match_nxt = {8'd0, byte_r};
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else begin
          pos_nxt   = pos_inc;
          rd_addr   = pos_inc;
          cnt_nxt   = cnt_r + (AW+1)'(1);
        end
      end
      S_ADD: begin
        match_nxt = {8'd0, byte_r};
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!outv_r) begin
          outv_nxt  = 1'b1;
          outc_nxt  = match_r;
          outf_nxt  = 1'b1;
          match_nxt = '0;
          held_nxt  = 1'b0;
          free_nxt  = 17'(lzw_pkg::FirstFree);
          pos_nxt   = '0;
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      match_r <= '0;
      held_r  <= 1'b0;
      free_r  <= 17'(lzw_pkg::FirstFree);
      pos_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      match_r <= match_nxt;
      held_r  <= held_nxt;
      free_r  <= free_nxt;
      pos_r   <= pos_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    outc_r <= outc_nxt;
    outf_r <= outf_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/lzw_checker.sv =====
// ----------------------------------------------------------------------------
// LZW encoder port checker
// Port-level checks on the encoder, bound to lzw_byte_encoder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lzw_byte_encoder_defines.svh"
module lzw_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire lzw_pkg::in_item_t  in_data,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire lzw_pkg::out_item_t out_data
);
  `LZW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "out transaction dropped")
  `LZW_ASSERT_NEXT(a_eos_busy, clk, rst_n, in_valid && in_ready && in_data.end_of_stream, !in_ready, "ready right after end of stream")
  `LZW_ASSERT_IMPL(a_final_code_range, clk, rst_n, out_valid && !out_data.final_code, out_data.code != 16'hFFFF, "code out of range")
endmodule

bind lzw_byte_encoder lzw_checker u_lzw_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
`default_nettype wire
